// ===== hdl/dss_pkg.sv =====
// Shared types and constants for the disk seek scheduler.
package dss_pkg;

    localparam int unsigned CFG_W     = 16;
    localparam int unsigned MODE_W    = 3;
    localparam int unsigned START_W   = 16;
    localparam int unsigned SEEK_W    = 22;
    localparam int unsigned OUT_CYL_W = 16;
    localparam int unsigned IN_CYL_W  = 16;

    localparam logic [SEEK_W-1:0] SEEK_MAX = {SEEK_W{1'b1}};

    // configuration register indexes
    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_START = 1'b1;

    // mode codes; unused codes behave as FCFS
    localparam logic [MODE_W-1:0] MODE_FCFS  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_SSTF  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_SCAN  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_CSCAN = 3'd3;
    localparam logic [MODE_W-1:0] MODE_LOOK  = 3'd4;

    typedef struct packed {
        logic [IN_CYL_W-1:0] request_cylinder;
        logic                last_request;
    } t_in;

    typedef struct packed {
        logic [OUT_CYL_W-1:0] served_cylinder;
        logic [SEEK_W-1:0]    seek_so_far;
        logic                 last_served;
    } t_out;

    typedef struct packed {
        logic busy;
    } t_back_status;

endpackage

// ===== hdl/dss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dss_ram #(
    parameter int unsigned WIDTH = 17,
    parameter int unsigned DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/dss_queue.sv =====
// Two-entry batch descriptor queue between front and back.
module dss_queue #(
    parameter int unsigned WIDTH = 26
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic             o_full,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wptr, r_rptr;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (i_push) begin
                r_mem[r_wptr] <= i_data;
                r_wptr        <= ~r_wptr;
            end
            if (i_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_data  = r_mem[r_rptr];

endmodule

// ===== hdl/dss_front.sv =====
// Front end: accepts requests, writes the store, closes batches.
module dss_front #(
    parameter int unsigned MAX_REQUESTS = 64,
    parameter int unsigned CYL_BITS     = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_in_valid,
    output logic                                          o_in_stall,
    input  dss_pkg::t_in                                  i_in,
    input  logic [dss_pkg::MODE_W-1:0]                    i_mode,
    input  logic [dss_pkg::START_W-1:0]                   i_start,
    input  dss_pkg::t_back_status                         i_back,
    input  logic                                          i_q_empty,
    output logic                                          o_q_push,
    output logic [$clog2(MAX_REQUESTS+1)+dss_pkg::MODE_W+dss_pkg::START_W-1:0] o_q_data,
    output logic                                          o_we,
    output logic [(MAX_REQUESTS > 1 ? $clog2(MAX_REQUESTS) : 1)-1:0] o_waddr,
    output logic [CYL_BITS:0]                             o_wdata
);

    localparam int unsigned AW = MAX_REQUESTS > 1 ? $clog2(MAX_REQUESTS) : 1;
    localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);

    logic [CW-1:0] r_cnt, n_cnt;
    logic          accept, close;

    // store is shared with the back end, so hold off while a batch is in flight
    assign o_in_stall = !i_q_empty || i_back.busy;
    assign accept     = i_in_valid && !o_in_stall;
    assign n_cnt      = r_cnt + CW'(1);
    assign close      = accept && (i_in.last_request || n_cnt == CW'(MAX_REQUESTS));

    assign o_we     = accept;
    assign o_waddr  = r_cnt[AW-1:0];
    assign o_wdata  = {1'b0, CYL_BITS'(i_in.request_cylinder)};
    assign o_q_push = close;
    assign o_q_data = {n_cnt, i_mode, i_start};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (close) begin
            r_cnt <= '0;
        end else if (accept) begin
            r_cnt <= n_cnt;
        end
    end

endmodule

// ===== hdl/dss_back.sv =====
// Back end: selection passes over the store and result emission.
module dss_back #(
    parameter int unsigned MAX_REQUESTS = 64,
    parameter int unsigned CYL_BITS     = 16
) (
    input  logic                                          i_clk,
    input  logic                                          i_rst_n,
    input  logic                                          i_q_empty,
    input  logic [$clog2(MAX_REQUESTS+1)+dss_pkg::MODE_W+dss_pkg::START_W-1:0] i_q_data,
    output logic                                          o_q_pop,
    output dss_pkg::t_back_status                         o_status,
    output logic                                          o_we,
    output logic [(MAX_REQUESTS > 1 ? $clog2(MAX_REQUESTS) : 1)-1:0] o_waddr,
    output logic [CYL_BITS:0]                             o_wdata,
    output logic [(MAX_REQUESTS > 1 ? $clog2(MAX_REQUESTS) : 1)-1:0] o_raddr,
    input  logic [CYL_BITS:0]                             i_rdata,
    output logic                                          o_out_valid,
    input  logic                                          i_out_stall,
    output dss_pkg::t_out                                 o_out
);

    localparam int unsigned AW = MAX_REQUESTS > 1 ? $clog2(MAX_REQUESTS) : 1;
    localparam int unsigned CW = $clog2(MAX_REQUESTS + 1);
    localparam int unsigned HW = CYL_BITS > dss_pkg::START_W ? CYL_BITS : dss_pkg::START_W;
    localparam int unsigned SW = (HW > dss_pkg::SEEK_W ? HW : dss_pkg::SEEK_W) + 1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_SCAN = 4'b0010,
        S_WAIT = 4'b0100,
        S_EMIT = 4'b1000
    } t_state;

    t_state                      r_state;
    logic [CW-1:0]               r_n, r_k, r_addr;
    logic [dss_pkg::MODE_W-1:0]  r_mode;
    logic [HW-1:0]               r_start, r_head, r_bcyl, r_bdist;
    logic [dss_pkg::SEEK_W-1:0]  r_seek;
    logic                        r_up, r_dv, r_found;
    logic [AW-1:0]               r_didx, r_bidx;
    logic                        r_ov;
    dss_pkg::t_out               r_out;

    logic [CW-1:0]               q_n;
    logic [dss_pkg::MODE_W-1:0]  q_mode;
    logic [dss_pkg::START_W-1:0] q_start;
    logic                        is_sstf, is_scan, is_cscan;
    logic                        ent_served, take;
    logic [HW-1:0]               ent_cyl, ent_dist, emit_dist;
    logic [SW-1:0]               seek_sum;
    logic [dss_pkg::SEEK_W-1:0]  seek_next;
    logic                        can_load, emit;

    assign {q_n, q_mode, q_start} = i_q_data;

    assign is_sstf  = (r_mode == dss_pkg::MODE_SSTF);
    assign is_scan  = (r_mode == dss_pkg::MODE_SCAN) || (r_mode == dss_pkg::MODE_LOOK);
    assign is_cscan = (r_mode == dss_pkg::MODE_CSCAN);

    assign ent_served = i_rdata[CYL_BITS];
    assign ent_cyl    = HW'(i_rdata[CYL_BITS-1:0]);
    assign ent_dist   = (r_head > ent_cyl) ? r_head - ent_cyl : ent_cyl - r_head;

    // candidate test; strict compares keep the earliest entry on ties
    always_comb begin
        priority if (is_sstf) begin
            take = !ent_served && (!r_found || ent_dist < r_bdist);
        end else if (is_scan && !r_up) begin
            take = !ent_served && ent_cyl <= r_start && (!r_found || ent_cyl > r_bcyl);
        end else if (is_cscan && !r_up) begin
            take = !ent_served && ent_cyl >= r_start && (!r_found || ent_cyl < r_bcyl);
        end else if (is_scan || is_cscan) begin
            take = !ent_served && (!r_found || ent_cyl < r_bcyl);
        end else begin
            take = (r_didx == r_k[AW-1:0]);
        end
    end

    assign emit_dist = (r_head > r_bcyl) ? r_head - r_bcyl : r_bcyl - r_head;
    assign seek_sum  = SW'(r_seek) + SW'(emit_dist);
    assign seek_next = (seek_sum > SW'(dss_pkg::SEEK_MAX)) ? dss_pkg::SEEK_MAX
                                                          : seek_sum[dss_pkg::SEEK_W-1:0];

    assign can_load = !r_ov || !i_out_stall;
    assign emit     = (r_state == S_EMIT) && !(!r_found && (is_scan || is_cscan) && !r_up)
                      && can_load;

    assign o_q_pop       = (r_state == S_IDLE) && !i_q_empty;
    assign o_status.busy = (r_state != S_IDLE);
    assign o_raddr       = r_addr[AW-1:0];
    assign o_we          = emit;
    assign o_waddr       = r_bidx;
    assign o_wdata       = {1'b1, r_bcyl[CYL_BITS-1:0]};
    assign o_out_valid   = r_ov;
    assign o_out         = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dv    <= 1'b0;
            r_ov    <= 1'b0;
            r_found <= 1'b0;
            r_up    <= 1'b0;
        end else begin
            if (r_ov && !i_out_stall) begin
                r_ov <= 1'b0;
            end
            r_dv <= (r_state == S_SCAN);
            if (r_state == S_SCAN) begin
                r_didx <= r_addr[AW-1:0];
            end
            if (r_dv && take) begin
                r_found <= 1'b1;
                r_bidx  <= r_didx;
                r_bcyl  <= ent_cyl;
                r_bdist <= ent_dist;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_n     <= q_n;
                        r_mode  <= q_mode;
                        r_start <= HW'(q_start);
                        r_head  <= HW'(q_start);
                        r_seek  <= '0;
                        r_up    <= 1'b0;
                        r_k     <= '0;
                        r_addr  <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    r_addr <= r_addr + CW'(1);
                    if (r_addr == r_n - CW'(1)) begin
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_found && (is_scan || is_cscan) && !r_up) begin
                        // first sweep phase empty: turn the sweep and rescan
                        r_up    <= 1'b1;
                        r_addr  <= '0;
                        r_state <= S_SCAN;
                    end else if (can_load) begin
                        r_ov                  <= 1'b1;
                        r_out.served_cylinder <= dss_pkg::OUT_CYL_W'(r_bcyl);
                        r_out.seek_so_far     <= seek_next;
                        r_out.last_served     <= (r_k == r_n - CW'(1));
                        r_head                <= r_bcyl;
                        r_seek                <= seek_next;
                        r_k                   <= r_k + CW'(1);
                        r_found               <= 1'b0;
                        r_addr                <= '0;
                        r_state <= (r_k == r_n - CW'(1)) ? S_IDLE : S_SCAN;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/disk_seek_scheduler.sv =====
// Disk seek scheduler top level: config registers, front, queue, back, store.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall / i_in): one cylinder request per
//    transfer; last_request closes the batch, as does a full store.
//  - Unless stalled, requests load at one per cycle into a store of MAX_REQUESTS entries.
//  - A closed batch goes into a two-entry queue; the back end then walks the
//    store once per result, with one more pass when a SCAN/LOOK/C-SCAN sweep
//    turns. The store's single read port is why each result needs a pass.
//  - Input stalls from batch close until the back end loads the last result.
//  - Output channel (o_out_valid / i_out_stall / o_out): one transfer per
//    served request, with the running seek distance; last_served marks the end.
//  - A stalled result holds in the output register; the back end waits.
//  - Config port: i_cfg_we writes register i_cfg_idx (0 mode, 1 start
//    cylinder); both are sampled when the batch closes.
//  - Reset (synchronous, active low) clears counts, queue, state and config;
//    the store needs no clearing since every entry is written before use.
module disk_seek_scheduler #(
    parameter int unsigned MAX_REQUESTS = 64,
    parameter int unsigned CYL_BITS     = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  dss_pkg::t_in                i_in,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output dss_pkg::t_out               o_out,
    input  logic                        i_cfg_we,
    input  logic                        i_cfg_idx,
    input  logic [dss_pkg::CFG_W-1:0]   i_cfg_data
);

    localparam int unsigned AW = MAX_REQUESTS > 1 ? $clog2(MAX_REQUESTS) : 1;
    localparam int unsigned QW = $clog2(MAX_REQUESTS + 1) + dss_pkg::MODE_W + dss_pkg::START_W;

    logic [dss_pkg::MODE_W-1:0]  r_mode;
    logic [dss_pkg::START_W-1:0] r_start;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= dss_pkg::MODE_FCFS;
            r_start <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                dss_pkg::REG_MODE:  r_mode  <= i_cfg_data[dss_pkg::MODE_W-1:0];
                dss_pkg::REG_START: r_start <= i_cfg_data[dss_pkg::START_W-1:0];
                default: ;
            endcase
        end
    end

    dss_pkg::t_back_status back_status;
    logic              q_push, q_pop, q_empty, q_full;
    logic [QW-1:0]     q_wdata, q_rdata;
    logic              fe_we, be_we;
    logic [AW-1:0]     fe_waddr, be_waddr, ram_raddr;
    logic [CYL_BITS:0] fe_wdata, be_wdata, ram_rdata;

    dss_front #(.MAX_REQUESTS(MAX_REQUESTS), .CYL_BITS(CYL_BITS)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .i_mode     (r_mode),
        .i_start    (r_start),
        .i_back     (back_status),
        .i_q_empty  (q_empty && !q_full),
        .o_q_push   (q_push),
        .o_q_data   (q_wdata),
        .o_we       (fe_we),
        .o_waddr    (fe_waddr),
        .o_wdata    (fe_wdata)
    );

    dss_queue #(.WIDTH(QW)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_wdata),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_data  (q_rdata)
    );

    dss_back #(.MAX_REQUESTS(MAX_REQUESTS), .CYL_BITS(CYL_BITS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (q_rdata),
        .o_q_pop     (q_pop),
        .o_status    (back_status),
        .o_we        (be_we),
        .o_waddr     (be_waddr),
        .o_wdata     (be_wdata),
        .o_raddr     (ram_raddr),
        .i_rdata     (ram_rdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // front and back never write in the same cycle
    dss_ram #(.WIDTH(CYL_BITS + 1), .DEPTH(MAX_REQUESTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (fe_we || be_we),
        .i_waddr (fe_we ? fe_waddr : be_waddr),
        .i_wdata (fe_we ? fe_wdata : be_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

endmodule
